/* rtl/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg: shared definitions for the Modbus RTU response checker
// Holds frame limits, error codes, configuration register indexes and the
// byte-wide Modbus CRC-16 update.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  // Frame limits
  localparam int unsigned MAX_FRAME_BYTES = 32;
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MIN_RESPONSE_BYTES = CNT_W'(7);
  localparam logic [7:0]       HEADER_OVERHEAD    = 8'd5;

  // Accepted function codes
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;

  // CRC constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_LENGTH = 1'b0;
  localparam logic CFG_DEVICE_ADDRESS  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [5:0] EXPECTED_LENGTH_RST = 6'd7;
  localparam logic [7:0] DEVICE_ADDRESS_RST  = 8'd254;

  // Result codes
  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_LENGTH     = 3'd1,
    ERR_TOO_SHORT  = 3'd2,
    ERR_CRC        = 3'd3,
    ERR_HEADER     = 3'd4
  } err_code_t;

  // One byte through the reflected CRC-16, bit by bit (eight narrow steps).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker: Modbus RTU read response checker
// Checks length, CRC and header of one received read response and reports
// the first register word.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a response arrive on the input channel (in_rx_byte, with
// in_last_byte high on the final byte). A byte transfers on a rising edge
// with in_valid high and in_stall low. Only the final byte of a frame
// produces a result on the output channel: frame_valid, error_code, the
// first register word (zero unless the frame passed) and the saturated
// frame length.
// A final byte passes through the input register and then the result
// register before its result is shown. Throughput: one byte per cycle while
// in_stall is low; the CRC of one byte is done in the cycle between the
// input register and the frame state. When the receiver stalls a pending
// result, further non-final bytes keep flowing; a final byte waits in the
// input register, and in_stall rises only once that register is held.
// Reset clears the frame state (CRC to 0xFFFF), both pipeline stages and
// sets expected_length to 7 and device_address to 254. Configuration is
// written through cfg_we, cfg_index and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_last_byte,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_frame_valid,
  output logic [2:0]          out_error_code,
  output logic [15:0]         out_register_value,
  output logic [5:0]          out_frame_length
);
  import mbrc_pkg::*;

  // Configuration registers
  logic [5:0]       expected_length_r;
  logic [7:0]       device_address_r;

  // Input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  // Frame state
  logic [15:0]      crc_r,       crc_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [7:0]       hdr_addr_r,  hdr_addr_nxt;
  logic [7:0]       hdr_func_r,  hdr_func_nxt;
  logic [7:0]       hdr_cnt_r,   hdr_cnt_nxt;
  logic [15:0]      data_word_r, data_word_nxt;
  logic [15:0]      tail_r,      tail_nxt;
  logic             ovf_r,       ovf_nxt;

  // Result register
  logic             out_valid_r;
  logic             out_frame_valid_r;
  logic [2:0]       out_error_code_r;
  logic [15:0]      out_register_value_r;
  logic [5:0]       out_frame_length_r;

  logic             out_free;
  logic             advance;
  err_code_t        code;
  logic [7:0]       len_minus_hdr;

  // Handshake: a final byte needs room in the result register.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !advance;

  // Frame state update for the byte in the input register
  always_comb begin
    crc_nxt       = crc_r;
    hdr_addr_nxt  = hdr_addr_r;
    hdr_func_nxt  = hdr_func_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    data_word_nxt = data_word_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;

    // The CRC runs two bytes behind, so the trailing CRC bytes stay out.
    if (count_r >= CNT_W'(2)) begin
      crc_nxt = crc16_byte(crc_r, tail_r[15:8]);
    end
    tail_nxt = {tail_r[7:0], s1_byte_r};

    unique case (count_r)
      CNT_W'(0): hdr_addr_nxt  = s1_byte_r;
      CNT_W'(1): hdr_func_nxt  = s1_byte_r;
      CNT_W'(2): hdr_cnt_nxt   = s1_byte_r;
      CNT_W'(3): data_word_nxt = {s1_byte_r, 8'h00};
      CNT_W'(4): data_word_nxt = {data_word_r[15:8], s1_byte_r};
      default: ;
    endcase

    // The count saturates at the buffer size and flags the overflow.
    if (count_r < CNT_W'(MAX_FRAME_BYTES)) begin
      count_nxt = count_r + CNT_W'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // Checks on the final byte, in order of precedence
  assign len_minus_hdr = 8'(count_nxt) - HEADER_OVERHEAD;

  always_comb begin
    priority if (ovf_nxt || (6'(count_nxt) != expected_length_r)) begin
      code = ERR_LENGTH;
    end else if (count_nxt < MIN_RESPONSE_BYTES) begin
      code = ERR_TOO_SHORT;
    end else if ((tail_nxt[15:8] != crc_nxt[7:0]) || (tail_nxt[7:0] != crc_nxt[15:8])) begin
      code = ERR_CRC;
    end else if ((hdr_addr_nxt != device_address_r) ||
                 ((hdr_func_nxt != FUNC_READ_HOLDING) && (hdr_func_nxt != FUNC_READ_INPUT)) ||
                 (hdr_cnt_nxt != len_minus_hdr)) begin
      code = ERR_HEADER;
    end else begin
      code = ERR_OK;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_length_r <= EXPECTED_LENGTH_RST;
      device_address_r  <= DEVICE_ADDRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_LENGTH: expected_length_r <= cfg_wdata[5:0];
        CFG_DEVICE_ADDRESS:  device_address_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Frame state: updated per byte, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      crc_r       <= CRC_INIT;
      count_r     <= '0;
      hdr_addr_r  <= '0;
      hdr_func_r  <= '0;
      hdr_cnt_r   <= '0;
      data_word_r <= '0;
      tail_r      <= '0;
      ovf_r       <= 1'b0;
    end else if (advance) begin
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      hdr_addr_r  <= hdr_addr_nxt;
      hdr_func_r  <= hdr_func_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      data_word_r <= data_word_nxt;
      tail_r      <= tail_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && s1_last_r) begin
      out_frame_valid_r    <= (code == ERR_OK);
      out_error_code_r     <= code;
      out_register_value_r <= (code == ERR_OK) ? data_word_nxt : 16'h0000;
      out_frame_length_r   <= 6'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_valid    = out_frame_valid_r;
  assign out_error_code     = out_error_code_r;
  assign out_register_value = out_register_value_r;
  assign out_frame_length   = out_frame_length_r;

endmodule

/* rtl/mbrc_checker.sv */
// ----------------------------------------------------------------------------
// mbrc_checker: port-level checks for the Modbus RTU response checker
// Watches the result channel and checks consistency of the reported fields.
// ----------------------------------------------------------------------------
module mbrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_frame_valid,
  input logic [2:0]  out_error_code,
  input logic [15:0] out_register_value,
  input logic [5:0]  out_frame_length
);
  import mbrc_pkg::*;

  // A passing frame reports the ok code, and only a passing frame does.
  a_valid_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_valid == (out_error_code == ERR_OK)))
    else $error("frame_valid disagrees with error_code");

  // A failed frame never leaks a register word.
  a_zero_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_valid) |-> (out_register_value == 16'h0000))
    else $error("register_value nonzero on a failed frame");

  // A passing frame is at least the minimum response length.
  a_min_len : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_valid) |-> (out_frame_length >= 6'(MIN_RESPONSE_BYTES)))
    else $error("passing frame shorter than the minimum response");

  // Length reported never exceeds the buffer size.
  a_max_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_length <= 6'(MAX_FRAME_BYTES)))
    else $error("frame_length above buffer size");

  // A stalled result stays and holds its payload.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_error_code) &&
                                  $stable(out_register_value) && $stable(out_frame_length)))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_response_checker mbrc_checker u_mbrc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_frame_valid    (out_frame_valid),
  .out_error_code     (out_error_code),
  .out_register_value (out_register_value),
  .out_frame_length   (out_frame_length)
);
